// ===== hdl/stt_pkg.sv =====
// Shared types and constants for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

	// Default width of the integer accumulator
	localparam int VALUE_BITS_DEF = 31;
	// Width of the integer value on the result port
	localparam int INT_W          = 31;
	// Up to three results come out of one item
	localparam int MAX_RES        = 3;
	localparam int CNT_W          = 2;
	// Packets held between front and back
	localparam int QDEPTH         = 4;

	// Token kinds as seen on the result port
	typedef enum logic [2:0] {
		KIND_IDENT   = 3'd0,
		KIND_STRING  = 3'd1,
		KIND_CHAR    = 3'd2,
		KIND_INTEGER = 3'd3,
		KIND_OPER    = 3'd4
	} kind_t;

	// Event codes
	localparam logic EV_CHAR = 1'b0;
	localparam logic EV_END  = 1'b1;

	// Character codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;

	// One result item
	typedef struct packed {
		logic             ev;
		kind_t            kind;
		logic [7:0]       chr;
		logic [INT_W-1:0] val;
	} result_t;

	// All results caused by one input item
	typedef struct packed {
		logic [CNT_W-1:0]          cnt;
		result_t [MAX_RES-1:0]     res;
	} packet_t;

	// Front to queue
	typedef struct packed {
		logic    wr_en;
		packet_t pkt;
	} q_wr_t;

	// Queue to back
	typedef struct packed {
		logic    empty;
		packet_t head;
	} q_rd_t;

endpackage

// ===== hdl/stt_front.sv =====
// Front end: accepts characters, runs the scanner state, builds result packets.
`timescale 1ns / 1ps

module stt_front #(
	parameter int VALUE_BITS = stt_pkg::VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       ch,
	input  logic             end_of_text,
	input  logic             push,
	input  logic             q_full,
	output stt_pkg::q_wr_t   q_wr
);

	localparam int IW = stt_pkg::INT_W;
	localparam int EW = VALUE_BITS + 4;

	typedef enum logic [2:0] {
		M_IDLE,
		M_IDENT,
		M_STRING,
		M_CHAR,
		M_INTEGER,
		M_OPER
	} mode_t;

	mode_t                 mode_q, mode_d;
	logic [7:0]            prev_q, prev_d;
	logic [VALUE_BITS-1:0] accum_q, accum_d;
	logic                  skip_q, skip_d;

	logic                  accept;
	logic                  is_ws, is_let, is_dig, is_stop, is_pm;
	logic [3:0]            dig;
	logic [EW-1:0]         acc_ext, acc_mul;
	logic [VALUE_BITS-1:0] acc_next;
	logic                  taken;
	logic [1:0]            n;
	stt_pkg::packet_t      pkt;

	function automatic stt_pkg::kind_t mode_kind(input mode_t m);
		stt_pkg::kind_t k;
		unique case (m)
			M_IDENT:   k = stt_pkg::KIND_IDENT;
			M_STRING:  k = stt_pkg::KIND_STRING;
			M_CHAR:    k = stt_pkg::KIND_CHAR;
			M_INTEGER: k = stt_pkg::KIND_INTEGER;
			default:   k = stt_pkg::KIND_OPER;
		endcase
		return k;
	endfunction

	function automatic stt_pkg::result_t mk(input logic ev, input stt_pkg::kind_t k,
			input logic [7:0] c, input logic [IW-1:0] v);
		stt_pkg::result_t r;
		r.ev   = ev;
		r.kind = k;
		r.chr  = c;
		r.val  = v;
		return r;
	endfunction

	assign accept = push && !q_full;

	// Character classes
	assign is_ws   = (ch == stt_pkg::CH_SPACE) || (ch == stt_pkg::CH_TAB) ||
	                 (ch == stt_pkg::CH_LF) || (ch == stt_pkg::CH_VT) ||
	                 (ch == stt_pkg::CH_FF) || (ch == stt_pkg::CH_CR);
	assign is_let  = ((ch >= stt_pkg::CH_LC_A) && (ch <= stt_pkg::CH_LC_Z)) ||
	                 ((ch >= stt_pkg::CH_UC_A) && (ch <= stt_pkg::CH_UC_Z));
	assign is_dig  = (ch >= stt_pkg::CH_ZERO) && (ch <= stt_pkg::CH_NINE);
	assign is_stop = (ch == stt_pkg::CH_SEMI) || (ch == stt_pkg::CH_LPAR) ||
	                 (ch == stt_pkg::CH_RPAR) || (ch == stt_pkg::CH_LBRACE) ||
	                 (ch == stt_pkg::CH_RBRACE) || (ch == stt_pkg::CH_TILDE) ||
	                 (ch == stt_pkg::CH_BANG) || (ch == stt_pkg::CH_QMARK);
	assign is_pm   = (ch == stt_pkg::CH_PLUS) || (ch == stt_pkg::CH_MINUS);
	assign dig     = ch[3:0];

	// Decimal accumulate: acc*10 + d, saturating at all ones
	assign acc_ext  = EW'(accum_q);
	assign acc_mul  = (acc_ext << 3) + (acc_ext << 1) + EW'(dig);
	assign acc_next = (|acc_mul[EW-1:VALUE_BITS]) ? '1 : acc_mul[VALUE_BITS-1:0];

	// Next state and result list for one character
	always_comb begin
		mode_d  = mode_q;
		prev_d  = prev_q;
		accum_d = accum_q;
		skip_d  = skip_q;
		taken   = 1'b0;
		n       = '0;
		pkt     = '0;

		if (!is_ws) begin
			if (skip_q) begin
				skip_d = 1'b0;
			end else begin
				unique case (mode_q)
					M_IDENT: begin
						if (is_let || is_dig) begin
							pkt.res[n] = mk(stt_pkg::EV_CHAR, stt_pkg::KIND_IDENT, ch, '0);
							n = n + 2'd1;
							taken = 1'b1;
						end else begin
							pkt.res[n] = mk(stt_pkg::EV_END, stt_pkg::KIND_IDENT, '0, '0);
							n = n + 2'd1;
							mode_d = M_IDLE;
							accum_d = '0;
						end
					end
					M_INTEGER: begin
						if (is_dig) begin
							accum_d = acc_next;
							pkt.res[n] = mk(stt_pkg::EV_CHAR, stt_pkg::KIND_INTEGER, ch, '0);
							n = n + 2'd1;
							taken = 1'b1;
						end else begin
							pkt.res[n] = mk(stt_pkg::EV_END, stt_pkg::KIND_INTEGER, '0,
								IW'(accum_q));
							n = n + 2'd1;
							mode_d = M_IDLE;
							accum_d = '0;
						end
					end
					M_OPER: begin
						if (!is_let && !is_dig && !is_stop && ((ch == prev_q) || !is_pm)) begin
							pkt.res[n] = mk(stt_pkg::EV_CHAR, stt_pkg::KIND_OPER, ch, '0);
							n = n + 2'd1;
							taken = 1'b1;
						end else begin
							pkt.res[n] = mk(stt_pkg::EV_END, stt_pkg::KIND_OPER, '0, '0);
							n = n + 2'd1;
							mode_d = M_IDLE;
							accum_d = '0;
						end
					end
					M_STRING: begin
						if (ch == stt_pkg::CH_DQUOTE) begin
							pkt.res[n] = mk(stt_pkg::EV_END, stt_pkg::KIND_STRING, '0, '0);
							mode_d = M_IDLE;
							accum_d = '0;
						end else begin
							pkt.res[n] = mk(stt_pkg::EV_CHAR, stt_pkg::KIND_STRING, ch, '0);
						end
						n = n + 2'd1;
						taken = 1'b1;
					end
					M_CHAR: begin
						pkt.res[n] = mk(stt_pkg::EV_CHAR, stt_pkg::KIND_CHAR, ch, '0);
						n = n + 2'd1;
						pkt.res[n] = mk(stt_pkg::EV_END, stt_pkg::KIND_CHAR, '0, '0);
						n = n + 2'd1;
						mode_d = M_IDLE;
						accum_d = '0;
						skip_d = 1'b1;
						taken = 1'b1;
					end
					default: begin
					end
				endcase

				// Start a new token
				if (!taken) begin
					if (is_let) begin
						mode_d = M_IDENT;
						pkt.res[n] = mk(stt_pkg::EV_CHAR, stt_pkg::KIND_IDENT, ch, '0);
						n = n + 2'd1;
					end else if (is_dig) begin
						mode_d = M_INTEGER;
						accum_d = VALUE_BITS'(dig);
						pkt.res[n] = mk(stt_pkg::EV_CHAR, stt_pkg::KIND_INTEGER, ch, '0);
						n = n + 2'd1;
					end else if (ch == stt_pkg::CH_DQUOTE) begin
						mode_d = M_STRING;
					end else if (ch == stt_pkg::CH_SQUOTE) begin
						mode_d = M_CHAR;
					end else begin
						mode_d = M_OPER;
						pkt.res[n] = mk(stt_pkg::EV_CHAR, stt_pkg::KIND_OPER, ch, '0);
						n = n + 2'd1;
					end
				end
			end
			prev_d = ch;
		end else if (mode_q == M_IDENT || mode_q == M_INTEGER || mode_q == M_OPER) begin
			// whitespace closes identifier, integer and operator
			pkt.res[n] = mk(stt_pkg::EV_END, mode_kind(mode_q), '0,
				(mode_q == M_INTEGER) ? IW'(accum_q) : '0);
			n = n + 2'd1;
			mode_d = M_IDLE;
			accum_d = '0;
		end

		// End of text closes whatever is open and resets the scanner
		if (end_of_text) begin
			if (mode_d != M_IDLE) begin
				pkt.res[n] = mk(stt_pkg::EV_END, mode_kind(mode_d), '0,
					(mode_d == M_INTEGER) ? IW'(accum_d) : '0);
				n = n + 2'd1;
			end
			mode_d  = M_IDLE;
			prev_d  = '0;
			accum_d = '0;
			skip_d  = 1'b0;
		end

		pkt.cnt = n;
	end

	assign q_wr.wr_en = accept && (n != '0);
	assign q_wr.pkt   = pkt;

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			prev_q  <= '0;
			accum_q <= '0;
			skip_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			prev_q  <= prev_d;
			accum_q <= accum_d;
			skip_q  <= skip_d;
		end
	end

	// A pending drop only follows a closed char token
	a_skip_idle: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (mode_q == M_IDLE))
		else $error("skip pending while a token is open");

	// End of text returns the scanner to reset
	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_text) |=> (mode_q == M_IDLE && !skip_q && accum_q == '0))
		else $error("scanner not reset after end of text");

endmodule

// ===== hdl/stt_queue.sv =====
// Packet queue between the front end and the result serializer.
`timescale 1ns / 1ps

module stt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_pkg::q_wr_t q_wr,
	output logic           full,
	input  logic           rd_en,
	output stt_pkg::q_rd_t q_rd
);

	localparam int D  = stt_pkg::QDEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	stt_pkg::packet_t mem_q [D];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full       = (cnt_q == CW'(D));
	assign q_rd.empty = (cnt_q == '0);
	assign q_rd.head  = mem_q[rd_ptr_q];
	assign do_wr      = q_wr.wr_en && !full;
	assign do_rd      = rd_en && !q_rd.empty;

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= q_wr.pkt;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// The front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_wr.wr_en && full))
		else $error("packet written while queue full");

endmodule

// ===== hdl/stt_back.sv =====
// Back end: walks each packet and hands results out through an output register.
`timescale 1ns / 1ps

module stt_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stt_pkg::q_rd_t               q_rd,
	output logic                         rd_en,
	input  logic                         pop,
	output logic                         empty,
	output stt_pkg::result_t             res,
	output logic                         res_last
);

	logic [1:0]       idx_q;
	logic             out_valid_q;
	stt_pkg::result_t out_res_q;
	logic             out_last_q;
	logic             load, last_of;

	assign load    = !q_rd.empty && (!out_valid_q || pop);
	assign last_of = (idx_q == (q_rd.head.cnt - 2'd1));
	assign rd_en   = load && last_of;

	assign empty    = !out_valid_q;
	assign res      = out_res_q;
	assign res_last = out_last_q;

	// Control: result index within the head packet, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last_of ? '0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q  <= q_rd.head.res[idx_q];
			out_last_q <= last_of;
		end
	end

	// Queued packets always carry at least one result
	a_head_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!q_rd.empty |-> (q_rd.head.cnt != '0))
		else $error("empty packet in queue");

	// Index stays inside the head packet
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_rd.empty |-> (idx_q < q_rd.head.cnt))
		else $error("result index past packet end");

	// Index is at the start whenever no packet is waiting
	a_idx_rest: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd.empty |-> (idx_q == '0))
		else $error("result index not rewound");

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: front end, packet queue, back end.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | push / full         | ch, end_of_text
//  result   | pop / empty         | event_res, kind, tok_char, int_value, last
//
// One character is taken per cycle while the packet queue has room; its 0 to 3
// results, if there are any, enter the queue as one packet in the same cycle.
// The back end emits one result per cycle while the result side pops; a first
// result goes through the packet queue, then the output register, to the ports.
// Reset clears the scanner state, the queue and the output valid flag.
// A stalled result side fills the four-packet queue, then full rises.
`timescale 1ns / 1ps

module source_text_tokenizer #(
	parameter int VALUE_BITS = stt_pkg::VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                ch,
	input  logic                      end_of_text,
	input  logic                      push,
	output logic                      full,
	output logic                      event_res,
	output logic [2:0]                kind,
	output logic [7:0]                tok_char,
	output logic [stt_pkg::INT_W-1:0] int_value,
	output logic                      last,
	output logic                      empty,
	input  logic                      pop
);

	stt_pkg::q_wr_t   q_wr;
	stt_pkg::q_rd_t   q_rd;
	logic             rd_en;
	stt_pkg::result_t res;

	stt_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.ch          (ch),
		.end_of_text (end_of_text),
		.push        (push),
		.q_full      (full),
		.q_wr        (q_wr)
	);

	stt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.full   (full),
		.rd_en  (rd_en),
		.q_rd   (q_rd)
	);

	stt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.rd_en    (rd_en),
		.pop      (pop),
		.empty    (empty),
		.res      (res),
		.res_last (last)
	);

	assign event_res = res.ev;
	assign kind      = 3'(res.kind);
	assign tok_char  = res.chr;
	assign int_value = res.val;

endmodule
